@@ sv/sbr_pkg.sv @@
package sbr_pkg;

  localparam int NumW  = 59;
  localparam int MagW  = 58;
  localparam int DenW  = 57;

  localparam logic [10:0] MaxRows     = 11'd1024;
  localparam logic [4:0]  MaxFeatures = 5'd16;

  localparam logic [1:0] FUNC_LOAD_X = 2'd0;
  localparam logic [1:0] FUNC_LOAD_Y = 2'd1;
  localparam logic [1:0] FUNC_START  = 2'd2;

  localparam logic [1:0] CFG_ITERATIONS    = 2'd0;
  localparam logic [1:0] CFG_LEARNING_RATE = 2'd1;
  localparam logic [1:0] CFG_ROW_COUNT     = 2'd2;
  localparam logic [1:0] CFG_FEATURE_COUNT = 2'd3;

  localparam logic signed [31:0] DMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] DMin = 32'sh8000_0000;

  typedef struct packed {
    logic [1:0]        func;
    logic [9:0]        row;
    logic [3:0]        col;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic [3:0]        feature;
    logic signed [31:0] estimate;
    logic              last;
  } out_t;

  typedef struct packed {
    logic       ld_x;
    logic       ld_y;
    logic       fit_start;
    logic       issue_acc;
    logic       issue_upd;
    logic       round0;
    logic [9:0] row;
    logic [3:0] feat;
    logic       eval;
    logic       best_clr;
    logic       div_start;
    logic       step_calc;
    logic       coef_upd;
    logic       out_load;
    logic [3:0] out_idx;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic signed [49:0] drop16(input logic signed [64:0] v);
    logic [64:0] m;
    logic [48:0] s;
    m = v[64] ? 65'(-v) : 65'(v);
    s = m[64:16];
    drop16 = v[64] ? -$signed({1'b0, s}) : $signed({1'b0, s});
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
    if (v > 51'sd2147483647) sat32 = DMax;
    else if (v < -51'sd2147483648) sat32 = DMin;
    else sat32 = v[31:0];
  endfunction

endpackage

@@ sv/sbr_div.sv @@
module sbr_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       found_i,
  input  logic                       neg_i,
  input  logic [sbr_pkg::MagW-1:0]   mag_i,
  input  logic [sbr_pkg::DenW-1:0]   den_i,
  output logic                       done_o,
  output logic signed [31:0]         quot_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [73:0] rem_q;
  logic [87:0] dsh_q;
  logic [31:0] q_q;
  logic        neg_q, sat_q;
  logic [73:0] dvd;
  logic        ge;

  assign dvd = {mag_i, 16'b0};
  assign ge  = {14'b0, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      cnt_q <= '0;
      if (!found_i || ({15'b0, dvd} >= {den_i, 32'b0})) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        busy_q <= 1'b1;
        done_q <= 1'b0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= found_i & neg_i;
      sat_q <= found_i && ({15'b0, dvd} >= {den_i, 32'b0});
      q_q   <= '0;
      rem_q <= dvd;
      dsh_q <= {den_i, 31'b0};
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - dsh_q[73:0];
      q_q   <= {q_q[30:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  always_comb begin
    if (sat_q) quot_o = neg_q ? sbr_pkg::DMin : sbr_pkg::DMax;
    else if (neg_q) quot_o = q_q[31] ? sbr_pkg::DMin : -$signed(q_q);
    else quot_o = q_q[31] ? sbr_pkg::DMax : $signed(q_q);
  end

  assign done_o = done_q;

endmodule

@@ sv/sbr_dp.sv @@
module sbr_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbr_pkg::cmd_t      cmd_i,
  input  sbr_pkg::in_t       in_data_i,
  input  logic [16:0]        lr_i,
  input  logic               out_stall_i,
  output sbr_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  output sbr_pkg::out_t      out_data_o
);

  logic signed [31:0] fmem [0:16383];
  logic signed [31:0] rmem [0:1023];
  logic signed [31:0] pmem [0:1023];

  logic signed [31:0] x_rd_q, r_rd_q, p_rd_q;
  logic               s1_v_q, s1_upd_q, s1_zero_q;
  logic [9:0]         s1_row_q;
  logic               s2_v_q, s2_upd_q;
  logic [9:0]         s2_row_q;
  logic signed [31:0] s2_pred_q;
  logic signed [64:0] mul_q;
  logic signed [63:0] xx_q;

  logic signed [sbr_pkg::NumW-1:0] num_q;
  logic [sbr_pkg::DenW-1:0]        den_q;
  logic                            found_q, best_neg_q;
  logic [sbr_pkg::MagW-1:0]        best_mag_q;
  logic [sbr_pkg::DenW-1:0]        best_den_q;
  logic [3:0]                      best_j_q;
  logic signed [31:0]              step_q;
  logic signed [31:0]              coef_q [0:15];
  logic                            out_valid_q;
  sbr_pkg::out_t                   out_q;

  logic [3:0]         rd_feat;
  logic signed [31:0] pred_b;
  logic signed [32:0] resid, opb;
  logic signed [64:0] mul_d;
  logic signed [63:0] xx_d;
  logic signed [49:0] dmul;
  logic signed [31:0] pred_new;
  logic [sbr_pkg::NumW-1:0] num_abs;
  logic               div_done;
  logic signed [31:0] quot;
  logic [31:0]        qmag;
  logic [48:0]        sprod;
  logic [32:0]        sm;
  logic signed [31:0] step_d;

  assign rd_feat = cmd_i.issue_upd ? best_j_q : cmd_i.feat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_x) fmem[{in_data_i.col, in_data_i.row}] <= in_data_i.value;
    x_rd_q <= fmem[{rd_feat, cmd_i.row}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_y) rmem[in_data_i.row] <= in_data_i.value;
    r_rd_q <= rmem[cmd_i.row];
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q && s2_upd_q) pmem[s2_row_q] <= pred_new;
    p_rd_q <= pmem[cmd_i.row];
  end

  assign pred_b = s1_zero_q ? 32'sd0 : p_rd_q;
  assign resid  = 33'(r_rd_q) - 33'(pred_b);
  assign opb    = s1_upd_q ? 33'(step_q) : resid;
  assign mul_d  = x_rd_q * opb;
  assign xx_d   = x_rd_q * x_rd_q;
  assign dmul   = sbr_pkg::drop16(mul_q);
  assign pred_new = sbr_pkg::sat32(51'(s2_pred_q) + 51'(dmul));
  assign num_abs  = num_q[sbr_pkg::NumW-1] ? sbr_pkg::NumW'(-num_q) : sbr_pkg::NumW'(num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue_acc | cmd_i.issue_upd;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_upd_q  <= cmd_i.issue_upd;
    s1_zero_q <= cmd_i.round0;
    s1_row_q  <= cmd_i.row;
    s2_upd_q  <= s1_upd_q;
    s2_row_q  <= s1_row_q;
    s2_pred_q <= pred_b;
    mul_q     <= mul_d;
    xx_q      <= xx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q   <= '0;
      den_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.fit_start || cmd_i.eval) begin
        num_q <= '0;
        den_q <= '0;
      end else if (s2_v_q && !s2_upd_q) begin
        num_q <= num_q + sbr_pkg::NumW'(dmul);
        den_q <= den_q + sbr_pkg::DenW'(xx_q[62:16]);
      end
      if (cmd_i.fit_start || cmd_i.best_clr) found_q <= 1'b0;
      else if (cmd_i.eval && den_q != '0 &&
               (!found_q || num_abs[sbr_pkg::MagW-1:0] > best_mag_q)) found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fit_start || cmd_i.best_clr) begin
      best_j_q <= '0;
    end else if (cmd_i.eval && den_q != '0 &&
                 (!found_q || num_abs[sbr_pkg::MagW-1:0] > best_mag_q)) begin
      best_j_q   <= cmd_i.feat;
      best_mag_q <= num_abs[sbr_pkg::MagW-1:0];
      best_neg_q <= num_q[sbr_pkg::NumW-1];
      best_den_q <= den_q;
    end
  end

  sbr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .found_i (found_q),
    .neg_i   (best_neg_q),
    .mag_i   (best_mag_q),
    .den_i   (best_den_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign qmag  = quot[31] ? 32'(-quot) : 32'(quot);
  assign sprod = qmag * lr_i;
  assign sm    = sprod[48:16];

  always_comb begin
    if (quot[31]) step_d = (sm[32:31] != 2'b00) ? sbr_pkg::DMin : -$signed(sm[31:0]);
    else step_d = (sm[32:31] != 2'b00) ? sbr_pkg::DMax : $signed(sm[31:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_calc) step_q <= step_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fit_start) begin
      for (int c = 0; c < 16; c++) coef_q[c] <= '0;
    end else if (cmd_i.coef_upd) begin
      coef_q[best_j_q] <= sbr_pkg::sat32(51'(coef_q[best_j_q]) + 51'(step_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.feature  <= cmd_i.out_idx;
      out_q.estimate <= coef_q[cmd_i.out_idx];
      out_q.last     <= cmd_i.out_last;
    end
  end

  assign sts_o.pipe_busy = s1_v_q | s2_v_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

@@ sv/sbr_ctrl.sv @@
module sbr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  sbr_pkg::in_t   in_data_i,
  output logic           in_stall_o,
  input  logic [15:0]    iterations_i,
  input  logic [10:0]    n_i,
  input  logic [4:0]     p_i,
  input  sbr_pkg::sts_t  sts_i,
  output sbr_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_ACC  = 4'd1;
  localparam logic [3:0] S_ACCW = 4'd2;
  localparam logic [3:0] S_DIVS = 4'd3;
  localparam logic [3:0] S_DIVW = 4'd4;
  localparam logic [3:0] S_STEP = 4'd5;
  localparam logic [3:0] S_COEF = 4'd6;
  localparam logic [3:0] S_UPD  = 4'd7;
  localparam logic [3:0] S_UPDW = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]  state_q, state_d;
  logic [10:0] i_q, i_d;
  logic [3:0]  j_q, j_d;
  logic [15:0] it_q, it_d;
  logic [3:0]  k_q, k_d;
  logic        acc;
  logic        j_last, k_last, it_last;

  assign acc     = in_valid_i && (state_q == S_IDLE);
  assign j_last  = ({1'b0, j_q} + 5'd1) == p_i;
  assign k_last  = ({1'b0, k_q} + 5'd1) == p_i;
  assign it_last = ({1'b0, it_q} + 17'd1) == {1'b0, iterations_i};
  assign in_stall_o = state_q != S_IDLE;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    it_d    = it_q;
    k_d     = k_q;
    cmd_o   = '0;
    cmd_o.row    = i_q[9:0];
    cmd_o.feat   = j_q;
    cmd_o.round0 = it_q == 16'd0;
    cmd_o.out_idx  = k_q;
    cmd_o.out_last = k_last;
    case (state_q)
      S_IDLE: begin
        cmd_o.ld_x      = acc && in_data_i.func == sbr_pkg::FUNC_LOAD_X;
        cmd_o.ld_y      = acc && in_data_i.func == sbr_pkg::FUNC_LOAD_Y;
        cmd_o.fit_start = acc && in_data_i.func == sbr_pkg::FUNC_START;
        if (cmd_o.fit_start) begin
          it_d = '0;
          j_d  = '0;
          i_d  = '0;
          k_d  = '0;
          state_d = (iterations_i == 16'd0) ? S_EMIT : S_ACC;
        end
      end
      S_ACC: begin
        if (i_q < n_i) begin
          cmd_o.issue_acc = 1'b1;
          i_d = i_q + 11'd1;
        end else begin
          state_d = S_ACCW;
        end
      end
      S_ACCW: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.eval = 1'b1;
          i_d = '0;
          if (j_last) begin
            state_d = S_DIVS;
          end else begin
            j_d = j_q + 4'd1;
            state_d = S_ACC;
          end
        end
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) state_d = S_STEP;
      end
      S_STEP: begin
        cmd_o.step_calc = 1'b1;
        state_d = S_COEF;
      end
      S_COEF: begin
        cmd_o.coef_upd = 1'b1;
        i_d = '0;
        state_d = S_UPD;
      end
      S_UPD: begin
        if (i_q < n_i) begin
          cmd_o.issue_upd = 1'b1;
          i_d = i_q + 11'd1;
        end else begin
          state_d = S_UPDW;
        end
      end
      S_UPDW: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.best_clr = 1'b1;
          i_d  = '0;
          j_d  = '0;
          it_d = it_q + 16'd1;
          state_d = it_last ? S_EMIT : S_ACC;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          k_d = k_q + 4'd1;
          if (k_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      it_q    <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      it_q    <= it_d;
      k_q     <= k_d;
    end
  end

endmodule

@@ sv/stagewise_boost_regression.sv @@
// Stagewise boosted linear regression in Q16.16. Load requests (feature or
// response value) are taken one per cycle and give no result. A start
// request runs iterations rounds; each round sweeps every feature over all
// rows through a single-port read pipeline, runs a 32-step restoring
// divider (skipped when no feature qualifies or the quotient saturates),
// then rewrites every prediction. Once the rounds are done the p
// coefficients leave at one per cycle while the output does not stall.
// Requests stall while a fit runs.
module stagewise_boost_regression (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  sbr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output sbr_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [1:0]    cfg_index_i,
  input  logic [16:0]   cfg_data_i
);

  logic [15:0] iter_q;
  logic [16:0] lr_q;
  logic [10:0] rows_q;
  logic [4:0]  feats_q;
  logic [10:0] n_use;
  logic [4:0]  p_use;

  sbr_pkg::cmd_t cmd;
  sbr_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q  <= 16'd1;
      lr_q    <= 17'd6554;
      rows_q  <= 11'd1024;
      feats_q <= 5'd16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        sbr_pkg::CFG_ITERATIONS:    iter_q  <= cfg_data_i[15:0];
        sbr_pkg::CFG_LEARNING_RATE: lr_q    <= cfg_data_i;
        sbr_pkg::CFG_ROW_COUNT:     rows_q  <= cfg_data_i[10:0];
        sbr_pkg::CFG_FEATURE_COUNT: feats_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign n_use = (rows_q > sbr_pkg::MaxRows) ? sbr_pkg::MaxRows : rows_q;
  assign p_use = (feats_q == 5'd0) ? 5'd1 :
                 (feats_q > sbr_pkg::MaxFeatures) ? sbr_pkg::MaxFeatures : feats_q;

  sbr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_data_i    (in_data_i),
    .in_stall_o   (in_stall_o),
    .iterations_i (iter_q),
    .n_i          (n_use),
    .p_i          (p_use),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  sbr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .lr_i        (lr_q),
    .out_stall_i (out_stall_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ dv/tb_stagewise_boost_regression.sv @@
`timescale 1ns / 100ps

module tb_stagewise_boost_regression;

  localparam int StallLimit = 3000000;
  localparam int NumRows    = 1024;
  localparam int NumFeat    = 16;
  localparam logic [1:0] FuncIgnored = 2'd3;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall_o;
  sbr_pkg::in_t  in_data;
  logic          out_valid_o;
  logic          out_stall;
  sbr_pkg::out_t out_data_o;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [16:0]   cfg_data;

  stagewise_boost_regression u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // mirror of the block's stores and registers
  logic signed [31:0] x_mem [NumFeat*NumRows];
  logic signed [31:0] y_mem [NumRows];
  longint             pred_mem [NumRows];
  longint             coef [NumFeat];
  int unsigned        n_iter, lrate, n_rows, n_feat;

  sbr_pkg::in_t  req_q [$];
  sbr_pkg::out_t coef_q [$];
  int   mismatches;
  bit   req_taken, coef_taken, calm;
  int   in_gap, out_gap, idle_cycles;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint trunc16(longint v);
    longint unsigned m;
    m = mag64(v) >> 16;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint sign_clamp(longint unsigned m, bit neg);
    if (neg) return (m >= 64'd2147483648) ? -64'sd2147483648 : -longint'(m);
    return (m > 64'd2147483647) ? 64'sd2147483647 : longint'(m);
  endfunction

  function automatic longint acc_add(longint a, longint b);
    if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (b < 0 && a < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - b) return 64'sh8000_0000_0000_0000;
    return a + b;
  endfunction

  function automatic longint fix_div(longint num, longint unsigned den);
    longint unsigned m, qi, rem, q;
    m = mag64(num);
    qi = m / den;
    rem = m % den;
    if (qi >= (64'd1 << 40)) return sign_clamp(64'hFFFF_FFFF_FFFF_FFFF, num < 0);
    q = qi;
    for (int k = 0; k < 16; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q = q | 64'd1;
      end
    end
    return sign_clamp(q, num < 0);
  endfunction

  function automatic void fit_coefs();
    int unsigned n, p, best_j;
    longint unsigned top_score, den, score, sm;
    longint num, r, x, top_step, q;
    bit found;
    sbr_pkg::out_t o;
    n = (n_rows > NumRows) ? NumRows : n_rows;
    p = (n_feat > NumFeat) ? NumFeat : n_feat;
    if (p == 0) p = 1;
    foreach (pred_mem[i]) pred_mem[i] = 0;
    foreach (coef[j]) coef[j] = 0;
    for (int unsigned it = 0; it < n_iter; it++) begin
      best_j = 0;
      top_score = 0;
      top_step = 0;
      found = 0;
      for (int unsigned j = 0; j < p; j++) begin
        num = 0;
        den = 0;
        for (int unsigned i = 0; i < n; i++) begin
          r = longint'(y_mem[i]) - pred_mem[i];
          x = longint'(x_mem[j*NumRows+i]);
          num = acc_add(num, trunc16(x * r));
          den += (mag64(x) * mag64(x)) >> 16;
        end
        if (den != 0) begin
          score = mag64(num);
          if (!found || score > top_score) begin
            q = fix_div(num, den);
            sm = (mag64(q) * longint'(lrate)) >> 16;
            found = 1;
            top_score = score;
            best_j = j;
            top_step = sign_clamp(sm, q < 0);
          end
        end
      end
      coef[best_j] = clamp32(coef[best_j] + top_step);
      for (int unsigned i = 0; i < n; i++)
        pred_mem[i] = clamp32(pred_mem[i] +
                              trunc16(top_step * longint'(x_mem[best_j*NumRows+i])));
    end
    for (int unsigned j = 0; j < p; j++) begin
      o.feature = 4'(j);
      o.estimate = 32'(coef[j]);
      o.last = (j + 1 == p);
      coef_q = {coef_q, o};
    end
  endfunction

  function automatic void apply_request(sbr_pkg::in_t t);
    case (t.func)
      sbr_pkg::FUNC_LOAD_X: x_mem[int'(t.col)*NumRows + int'(t.row)] = t.value;
      sbr_pkg::FUNC_LOAD_Y: y_mem[t.row] = t.value;
      sbr_pkg::FUNC_START:  fit_coefs();
      default: ;
    endcase
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // request acceptance and prediction
  always @(posedge clk_i) begin
    req_taken <= rst_ni && in_valid && !in_stall_o;
    if (rst_ni && in_valid && !in_stall_o) begin
      apply_request(in_data);
    end
  end

  always @(negedge clk_i) begin
    logic nv;
    sbr_pkg::in_t nd;
    if (rst_ni && (req_taken || !in_valid)) begin
      nv = 1'b0;
      nd = in_data;
      if (in_gap > 0) begin
        in_gap--;
      end else if (req_q.size() > 0) begin
        nd = req_q.pop_front();
        nv = 1'b1;
        in_gap = calm ? 0 : $urandom_range(0, 5);
      end
      in_valid <= nv;
      in_data  <= nd;
    end
  end

  // result check
  always @(posedge clk_i) begin
    sbr_pkg::out_t e;
    coef_taken <= rst_ni && out_valid_o && !out_stall;
    if (rst_ni && out_valid_o && !out_stall) begin
      if (coef_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected coefficient: feature %0d estimate %h last %0d",
                   out_data_o.feature, out_data_o.estimate, out_data_o.last);
      end else begin
        e = coef_q.pop_front();
        if (e !== out_data_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("coefficient mismatch: expected f%0d %h l%0d, got f%0d %h l%0d",
                     e.feature, e.estimate, e.last,
                     out_data_o.feature, out_data_o.estimate, out_data_o.last);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (coef_taken) out_gap = calm ? 0 : $urandom_range(0, 5);
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("stagewise_boost_regression verification failed");
        $finish;
      end
    end
  end

  task automatic drain();
    while (req_q.size() > 0 || in_valid || coef_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, int unsigned val);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 17'(val);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      sbr_pkg::CFG_ITERATIONS:    n_iter = val & 32'hFFFF;
      sbr_pkg::CFG_LEARNING_RATE: lrate  = val & 32'h1FFFF;
      sbr_pkg::CFG_ROW_COUNT:     n_rows = val & 32'h7FF;
      default:                    n_feat = val & 32'h1F;
    endcase
  endtask

  task automatic set_all(int unsigned it, int unsigned lr, int unsigned n, int unsigned p);
    drain();
    cfg_write(sbr_pkg::CFG_ITERATIONS, it);
    cfg_write(sbr_pkg::CFG_LEARNING_RATE, lr);
    cfg_write(sbr_pkg::CFG_ROW_COUNT, n);
    cfg_write(sbr_pkg::CFG_FEATURE_COUNT, p);
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4: return $urandom();
      default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic void push_req(logic [1:0] f, int unsigned r, int unsigned c,
                                   logic [31:0] v);
    sbr_pkg::in_t t;
    t.func = f;
    t.row = 10'(r);
    t.col = 4'(c);
    t.value = v;
    req_q = {req_q, t};
  endfunction

  function automatic void fill(int unsigned n, int unsigned p, bit zero_cols);
    for (int unsigned i = 0; i < n; i++) begin
      push_req(sbr_pkg::FUNC_LOAD_Y, i, $urandom_range(0, 15), rand_value());
      for (int unsigned j = 0; j < p; j++)
        push_req(sbr_pkg::FUNC_LOAD_X, i, j, zero_cols ? 32'h0 : rand_value());
    end
  endfunction

  function automatic void random_mix(int unsigned cnt, int unsigned n, int unsigned p);
    int unsigned k;
    for (int unsigned m = 0; m < cnt; m++) begin
      k = $urandom_range(0, 99);
      if (k < 40) push_req(sbr_pkg::FUNC_LOAD_X, $urandom_range(0, n - 1),
                           $urandom_range(0, p - 1), rand_value());
      else if (k < 55) push_req(sbr_pkg::FUNC_LOAD_Y, $urandom_range(0, n - 1), $urandom(),
                                rand_value());
      else if (k < 65) push_req(sbr_pkg::FUNC_LOAD_X, $urandom(), $urandom(), rand_value());
      else if (k < 72) push_req(FuncIgnored, $urandom(), $urandom(), $urandom());
      else push_req(sbr_pkg::FUNC_START, $urandom(), $urandom(), $urandom());
    end
  endfunction

  initial begin
    int unsigned n, p;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    in_gap = 0;
    out_gap = 0;
    idle_cycles = 0;
    calm = 1'b0;
    n_iter = 1;
    lrate = 6554;
    n_rows = 1024;
    n_feat = 16;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extremes, a zero column, ignored func
    set_all(1, 65536, 4, 3);
    fill(4, 3, 0);
    for (int unsigned i = 0; i < 4; i++) push_req(sbr_pkg::FUNC_LOAD_X, i, 1, 32'h0);
    push_req(sbr_pkg::FUNC_LOAD_X, 0, 0, 32'h7FFF_FFFF);
    push_req(sbr_pkg::FUNC_LOAD_X, 1023, 15, 32'h8000_0000);
    push_req(sbr_pkg::FUNC_LOAD_Y, 0, 0, 32'h8000_0000);
    push_req(FuncIgnored, 1023, 15, 32'hFFFF_FFFF);
    push_req(sbr_pkg::FUNC_START, 0, 0, 0);

    // every feature skipped, then a normal fit
    set_all(3, 65536, 1, 16);
    fill(1, 16, 1);
    push_req(sbr_pkg::FUNC_START, 0, 0, 0);
    push_req(sbr_pkg::FUNC_LOAD_X, 0, 5, 32'h0001_0000);
    push_req(sbr_pkg::FUNC_LOAD_X, 0, 9, 32'hFFFF_0000);
    push_req(sbr_pkg::FUNC_START, 0, 0, 0);

    calm = 1'b1;
    set_all(16000, 1, 1, 1);
    fill(1, 1, 0);
    push_req(sbr_pkg::FUNC_START, 0, 0, 0);
    calm = 1'b0;

    set_all(1, 6554, 40, 1);
    fill(40, 1, 0);
    push_req(sbr_pkg::FUNC_START, 0, 0, 0);

    for (int ph = 0; ph < 4; ph++) begin
      n = $urandom_range(1, 6);
      p = $urandom_range(1, 6);
      set_all($urandom_range(1, 20), $urandom_range(1, 65536), n, p);
      calm = (ph % 3 == 2);
      fill(n, p, 0);
      random_mix(10, n, p);
      drain();
      random_mix(10, n, p);
    end

    drain();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && coef_q.size() == 0) begin
      $display("stagewise_boost_regression verification clean");
    end else begin
      $display("stagewise_boost_regression verification failed");
    end
    $finish;
  end

endmodule
